FILE: src/websocket_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("websocket frame receiver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("websocket frame receiver assertion failed");

`endif

FILE: src/wfr_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package wfr_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_LEN     = 4'd1,
    PH_EXT     = 4'd2,
    PH_MASK1   = 4'd3,
    PH_MASK2   = 4'd4,
    PH_MASK3   = 4'd5,
    PH_MASK4   = 4'd6,
    PH_PAYLOAD = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    EV_PENDING = 3'd0,
    EV_DATA    = 3'd1,
    EV_CLOSE   = 3'd2,
    EV_PING    = 3'd3,
    EV_PONG    = 3'd4,
    EV_FRAG    = 3'd5,
    EV_UNKNOWN = 3'd6
  } event_e;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    event_e     event_res;
  } result_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'ha;

  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

FILE: src/wfr_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the frame state and computes the result of one received byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_macros.svh"

module wfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  output wfr_pkg::result_t result_o
);

  wfr_pkg::phase_e phase_q, phase_d;
  wfr_pkg::event_e frame_kind_q, frame_kind_d;
  logic            masked_q, masked_d;
  logic [63:0]     len_q, len_d;
  logic [3:0]      ext_left_q, ext_left_d;
  logic [31:0]     mask_key_q, mask_key_d;
  logic [1:0]      mask_pos_q, mask_pos_d;
  logic [63:0]     rcvd_q, rcvd_d;
  logic [63:0]     rcvd_inc;
  logic [7:0]      mask_byte;
  logic            hdr_done;
  logic [3:0]      opcode;

  assign opcode   = rx_byte_i[3:0];
  assign rcvd_inc = rcvd_q + 64'd1;

  always_comb begin
    case (mask_pos_q)
      2'd0:    mask_byte = mask_key_q[31:24];
      2'd1:    mask_byte = mask_key_q[23:16];
      2'd2:    mask_byte = mask_key_q[15:8];
      default: mask_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    frame_kind_d = frame_kind_q;
    masked_d     = masked_q;
    len_d        = len_q;
    ext_left_d   = ext_left_q;
    mask_key_d   = mask_key_q;
    mask_pos_d   = mask_pos_q;
    rcvd_d       = rcvd_q;
    hdr_done     = 1'b0;
    result_o.byte_valid = 1'b0;
    result_o.out_byte   = 8'h00;
    result_o.event_res  = wfr_pkg::EV_PENDING;

    unique case (phase_q)
      wfr_pkg::PH_LEN: begin
        masked_d   = rx_byte_i[7];
        mask_key_d = 32'h0;
        len_d      = {57'h0, rx_byte_i[6:0]};
        if (rx_byte_i[6:0] == wfr_pkg::LEN_EXT16) begin
          ext_left_d = wfr_pkg::EXT16_BYTES;
          len_d      = 64'h0;
          phase_d    = wfr_pkg::PH_EXT;
        end else if (rx_byte_i[6:0] == wfr_pkg::LEN_EXT64) begin
          ext_left_d = wfr_pkg::EXT64_BYTES;
          len_d      = 64'h0;
          phase_d    = wfr_pkg::PH_EXT;
        end else if (rx_byte_i[7]) begin
          phase_d = wfr_pkg::PH_MASK1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      wfr_pkg::PH_EXT: begin
        len_d      = {len_q[55:0], rx_byte_i};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          if (masked_q) begin
            phase_d = wfr_pkg::PH_MASK1;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      wfr_pkg::PH_MASK1: begin
        mask_key_d = {mask_key_q[23:0], rx_byte_i};
        phase_d    = wfr_pkg::PH_MASK2;
      end
      wfr_pkg::PH_MASK2: begin
        mask_key_d = {mask_key_q[23:0], rx_byte_i};
        phase_d    = wfr_pkg::PH_MASK3;
      end
      wfr_pkg::PH_MASK3: begin
        mask_key_d = {mask_key_q[23:0], rx_byte_i};
        phase_d    = wfr_pkg::PH_MASK4;
      end
      wfr_pkg::PH_MASK4: begin
        mask_key_d = {mask_key_q[23:0], rx_byte_i};
        hdr_done   = 1'b1;
      end
      wfr_pkg::PH_PAYLOAD: begin
        result_o.byte_valid = 1'b1;
        result_o.out_byte   = rx_byte_i ^ mask_byte;
        mask_pos_d          = mask_pos_q + 2'd1;
        rcvd_d              = rcvd_inc;
        if (rcvd_inc >= len_q) begin
          phase_d            = wfr_pkg::PH_HEADER;
          rcvd_d             = 64'h0;
          result_o.event_res = frame_kind_q;
        end
      end
      default: begin
        phase_d = wfr_pkg::PH_HEADER;
        unique case (opcode) inside
          wfr_pkg::OP_CONT: begin
            result_o.event_res = wfr_pkg::EV_FRAG;
          end
          wfr_pkg::OP_TEXT, wfr_pkg::OP_BINARY: begin
            if (!rx_byte_i[7]) begin
              result_o.event_res = wfr_pkg::EV_FRAG;
            end else begin
              frame_kind_d = wfr_pkg::EV_DATA;
              phase_d      = wfr_pkg::PH_LEN;
            end
          end
          wfr_pkg::OP_CLOSE: begin
            frame_kind_d = wfr_pkg::EV_CLOSE;
            phase_d      = wfr_pkg::PH_LEN;
          end
          wfr_pkg::OP_PING: begin
            frame_kind_d = wfr_pkg::EV_PING;
            phase_d      = wfr_pkg::PH_LEN;
          end
          wfr_pkg::OP_PONG: begin
            frame_kind_d = wfr_pkg::EV_PONG;
            phase_d      = wfr_pkg::PH_LEN;
          end
          default: begin
            result_o.event_res = wfr_pkg::EV_UNKNOWN;
          end
        endcase
        if (phase_d == wfr_pkg::PH_LEN) begin
          mask_pos_d = 2'd0;
          rcvd_d     = 64'h0;
        end
      end
    endcase

    // An empty frame ends on its last header byte.
    if (hdr_done) begin
      mask_pos_d = 2'd0;
      rcvd_d     = 64'h0;
      if (len_d == 64'h0) begin
        phase_d            = wfr_pkg::PH_HEADER;
        result_o.event_res = frame_kind_q;
      end else begin
        phase_d = wfr_pkg::PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wfr_pkg::PH_HEADER;
      frame_kind_q <= wfr_pkg::EV_PENDING;
      masked_q     <= 1'b0;
      len_q        <= 64'h0;
      ext_left_q   <= 4'd0;
      mask_key_q   <= 32'h0;
      mask_pos_q   <= 2'd0;
      rcvd_q       <= 64'h0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      frame_kind_q <= frame_kind_d;
      masked_q     <= masked_d;
      len_q        <= len_d;
      ext_left_q   <= ext_left_d;
      mask_key_q   <= mask_key_d;
      mask_pos_q   <= mask_pos_d;
      rcvd_q       <= rcvd_d;
    end
  end

  `WFR_ASSERT_SAME(a_byte_only_in_payload, clk_i, rst_ni, result_o.byte_valid, phase_q == wfr_pkg::PH_PAYLOAD)
  `WFR_ASSERT_SAME(a_idle_byte_zero, clk_i, rst_ni, !result_o.byte_valid, result_o.out_byte == 8'h00)
  `WFR_ASSERT_SAME(a_errors_at_header, clk_i, rst_ni, (result_o.event_res == wfr_pkg::EV_FRAG) || (result_o.event_res == wfr_pkg::EV_UNKNOWN), phase_q == wfr_pkg::PH_HEADER)
  `WFR_ASSERT_NEXT(a_frame_end_to_header, clk_i, rst_ni, fire_i && (result_o.event_res != wfr_pkg::EV_PENDING), phase_q == wfr_pkg::PH_HEADER)

endmodule

FILE: src/wfr_out_buf.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver output buffer
// Output register with a skid stage, so that the input side keeps flowing.
// ----------------------------------------------------------------------------
module wfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wfr_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wfr_pkg::result_t result_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  wfr_pkg::result_t out_q;
  wfr_pkg::result_t skid_q;
  logic             in_fire;
  logic             out_fire;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= result_i;
      end else begin
        skid_q <= result_i;
      end
    end
  end

endmodule

FILE: src/websocket_frame_receiver.sv
// Results are registered in the output buffer, or in its skid register while the output stalls.
// Throughput: one byte per cycle while in_stall_o is low; the parser updates its state per accepted byte.
// The skid stage lets input continue for one item while the output stalls.
// Reset: asynchronous, active low; the parser returns to header start.
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Parses a received byte stream into frames, unmasks payload and reports
// the kind of each frame as it ends, or flags fragments and unknown opcodes.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] event_res_o
);

  wfr_pkg::result_t res;
  wfr_pkg::result_t res_out;
  logic             fire;

  assign fire = in_valid_i && !in_stall_o;

  wfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (rx_byte_i),
    .result_o  (res)
  );

  wfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_out)
  );

  assign byte_valid_o = res_out.byte_valid;
  assign out_byte_o   = res_out.out_byte;
  assign event_res_o  = res_out.event_res;

endmodule
